// File: sv/rcwm_pkg.sv
package rcwm_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_KERNEL = 7;

    // field widths
    localparam int NCH      = 3;
    localparam int COMP_W   = 8;
    localparam int PIX_W    = NCH * COMP_W;
    localparam int WGT_W    = 16;
    localparam int BIAS_W   = 24;
    localparam int SUM_W    = 32;
    localparam int POS_W    = 9;
    localparam int KS_W     = 3;
    localparam int CHAN_W   = 2;
    localparam int FILT_W   = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMERGE,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic vld;
    } t_mac_ctl;

endpackage

// File: sv/rcwm_ram.sv
module rcwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rcwm_mac.sv
module rcwm_mac #(
    parameter int MAX_KERNEL = rcwm_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rcwm_pkg::t_mac_ctl                     i_ctl,
    input  logic [rcwm_pkg::PIX_W-1:0]             i_pix,
    input  logic [rcwm_pkg::NCH*rcwm_pkg::WGT_W-1:0] i_wgt,
    input  logic signed [rcwm_pkg::BIAS_W-1:0]     i_bias,
    output logic signed [rcwm_pkg::SUM_W-1:0]      o_sum
);

    localparam int PROD_W  = rcwm_pkg::COMP_W + 1 + rcwm_pkg::WGT_W;
    localparam int ACC_RAW = PROD_W + 1 + $clog2(rcwm_pkg::NCH * MAX_KERNEL * MAX_KERNEL + 1);
    localparam int ACC_W   = (ACC_RAW > rcwm_pkg::SUM_W) ? ACC_RAW : rcwm_pkg::SUM_W + 1;
    localparam int SUM3_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-rcwm_pkg::SUM_W+1){1'b0}}, {(rcwm_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-rcwm_pkg::SUM_W+1){1'b1}}, {(rcwm_pkg::SUM_W-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod [rcwm_pkg::NCH];
    logic                     r_vld_a;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] n_prod [rcwm_pkg::NCH];
    logic signed [SUM3_W-1:0] sum3;

    // red sits in the top byte of a pixel, channel 0 of the weight word in the low bits
    always_comb begin
        for (int ch = 0; ch < rcwm_pkg::NCH; ch++) begin
            n_prod[ch] = $signed({1'b0, i_pix[(rcwm_pkg::NCH-1-ch)*rcwm_pkg::COMP_W +:
                                              rcwm_pkg::COMP_W]})
                       * $signed(i_wgt[ch*rcwm_pkg::WGT_W +: rcwm_pkg::WGT_W]);
        end
    end

    always_comb begin
        sum3 = '0;
        for (int ch = 0; ch < rcwm_pkg::NCH; ch++) begin
            sum3 = sum3 + SUM3_W'(r_prod[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= n_prod;
        end
        if (i_ctl.clear) begin
            r_acc <= ACC_W'(i_bias);
        end else if (r_vld_a) begin
            r_acc <= r_acc + ACC_W'(sum3);
        end
    end

    always_comb begin
        if (r_acc > SAT_HI) begin
            o_sum = SAT_HI[rcwm_pkg::SUM_W-1:0];
        end else if (r_acc < SAT_LO) begin
            o_sum = SAT_LO[rcwm_pkg::SUM_W-1:0];
        end else begin
            o_sum = r_acc[rcwm_pkg::SUM_W-1:0];
        end
    end

endmodule

// File: sv/rgb_conv_window_mac.sv
// compute: accepted in idle, then the window states, the drain state and the output state,
// which waits while an unsent result is held; one pixel read per window cycle
// throughput: pixel write every cycle while idle; no new item is taken during a compute
// or during the read-modify-write of the three-channel weight word after a weight write
// synchronous active-low reset initialises control and config registers only;
// the pixel and weight stores are not cleared
module rgb_conv_window_mac #(
    parameter int MAX_HEIGHT = rcwm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = rcwm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = rcwm_pkg::DEF_MAX_KERNEL
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // row[8:0] col[17:9] color_channel[19:18] weight_value[35:20] red[43:36]
    // green[51:44] blue[59:52] filter_number[67:60], zero[71:68]
    input  logic [rcwm_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // operation[1:0]
    input  logic [rcwm_pkg::OP_W-1:0]           s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sum_out[31:0] out_row[40:32] out_col[49:41] out_filter[57:50], zero[63:58]
    output logic [rcwm_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rcwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PIX_DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int PAW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int WWORD_W = rcwm_pkg::NCH * rcwm_pkg::WGT_W;
    localparam int KS_W  = rcwm_pkg::KS_W;
    localparam int POS_W = rcwm_pkg::POS_W;
    localparam int WIN_W = POS_W + 2;

    // input fields
    logic [rcwm_pkg::OP_W-1:0]   in_op;
    logic [POS_W-1:0]            in_row;
    logic [POS_W-1:0]            in_col;
    logic [rcwm_pkg::CHAN_W-1:0] in_chan;
    logic [rcwm_pkg::WGT_W-1:0]  in_wgt;
    logic [rcwm_pkg::PIX_W-1:0]  in_pix;
    logic [rcwm_pkg::FILT_W-1:0] in_filt;

    assign in_op   = s_axis_tuser;
    assign in_row  = s_axis_tdata[8:0];
    assign in_col  = s_axis_tdata[17:9];
    assign in_chan = s_axis_tdata[19:18];
    assign in_wgt  = s_axis_tdata[35:20];
    assign in_pix  = {s_axis_tdata[43:36], s_axis_tdata[51:44], s_axis_tdata[59:52]};
    assign in_filt = s_axis_tdata[67:60];

    rcwm_pkg::t_state r_state, n_state;

    logic [POS_W-1:0]                 r_img_w, r_img_h;
    logic [KS_W-1:0]                  r_ksize;
    logic signed [rcwm_pkg::BIAS_W-1:0] r_bias;

    logic [POS_W-1:0]            r_row, r_col;
    logic [rcwm_pkg::FILT_W-1:0] r_filt;
    logic [KS_W-1:0]             r_k, r_q;
    logic                        r_drain;
    logic                        r_s1_vld;
    logic [rcwm_pkg::CHAN_W-1:0] r_wsel;
    logic [WAW-1:0]              r_waddr;
    logic [rcwm_pkg::WGT_W-1:0]  r_wval;

    logic                              r_out_vld;
    logic [rcwm_pkg::SUM_W-1:0]        r_out_sum;
    logic [POS_W-1:0]                  r_out_row, r_out_col;
    logic [rcwm_pkg::FILT_W-1:0]       r_out_filt;

    logic [POS_W-1:0] w_eff, h_eff;
    logic [KS_W-1:0]  ks_eff, half;
    logic             in_xfer;
    logic             wgt_ok, pix_ok;
    logic             last_q, last_win;
    logic [WIN_W-1:0] pr, pc;
    logic             win_in;
    logic             load_out;

    logic               pix_we;
    logic [PAW-1:0]     pix_waddr, pix_raddr;
    logic [rcwm_pkg::PIX_W-1:0] pix_rdata;
    logic               wgt_we;
    logic [WAW-1:0]     wgt_raddr;
    logic [WWORD_W-1:0] wgt_wdata, wgt_rdata;

    rcwm_pkg::t_mac_ctl        mac_ctl;
    logic signed [rcwm_pkg::SUM_W-1:0] mac_sum;

    // effective sizes after saturation to the store limits
    assign w_eff  = (int'(r_img_w) > MAX_WIDTH)  ? POS_W'(MAX_WIDTH)  : r_img_w;
    assign h_eff  = (int'(r_img_h) > MAX_HEIGHT) ? POS_W'(MAX_HEIGHT) : r_img_h;
    assign ks_eff = (int'(r_ksize) > MAX_KERNEL) ? KS_W'(MAX_KERNEL)  : r_ksize;
    assign half   = ks_eff >> 1;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign wgt_ok  = (in_chan < rcwm_pkg::CHAN_W'(rcwm_pkg::NCH))
                  && (int'(in_row) < MAX_KERNEL) && (int'(in_col) < MAX_KERNEL);
    assign pix_ok  = (int'(in_row) < MAX_HEIGHT) && (int'(in_col) < MAX_WIDTH);

    // window position, two's complement so that positions left of or above the image go negative
    assign pr = WIN_W'(r_row) - WIN_W'(half) + WIN_W'(r_k);
    assign pc = WIN_W'(r_col) - WIN_W'(half) + WIN_W'(r_q);
    assign win_in = !pr[WIN_W-1] && (pr[WIN_W-2:0] < (WIN_W-1)'(h_eff))
                 && !pc[WIN_W-1] && (pc[WIN_W-2:0] < (WIN_W-1)'(w_eff));

    assign last_q   = (r_q == ks_eff - KS_W'(1));
    assign last_win = last_q && (r_k == ks_eff - KS_W'(1));

    assign pix_waddr = PAW'(int'(in_row) * MAX_WIDTH + int'(in_col));
    assign pix_raddr = PAW'(int'(pr[WIN_W-2:0]) * MAX_WIDTH + int'(pc[WIN_W-2:0]));

    always_comb begin
        for (int ch = 0; ch < rcwm_pkg::NCH; ch++) begin
            if (int'(r_wsel) == ch) begin
                wgt_wdata[ch*rcwm_pkg::WGT_W +: rcwm_pkg::WGT_W] = r_wval;
            end else begin
                wgt_wdata[ch*rcwm_pkg::WGT_W +: rcwm_pkg::WGT_W] =
                    wgt_rdata[ch*rcwm_pkg::WGT_W +: rcwm_pkg::WGT_W];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcwm_pkg::S_IDLE: begin
                if (in_xfer && in_op == rcwm_pkg::OP_COMPUTE) begin
                    n_state = (ks_eff == '0) ? rcwm_pkg::S_DRAIN : rcwm_pkg::S_RUN;
                end else if (in_xfer && in_op == rcwm_pkg::OP_WEIGHT && wgt_ok) begin
                    n_state = rcwm_pkg::S_WMERGE;
                end
            end
            rcwm_pkg::S_WMERGE: n_state = rcwm_pkg::S_IDLE;
            rcwm_pkg::S_RUN: begin
                if (last_win) begin
                    n_state = rcwm_pkg::S_DRAIN;
                end
            end
            rcwm_pkg::S_DRAIN: begin
                if (r_drain) begin
                    n_state = rcwm_pkg::S_OUT;
                end
            end
            rcwm_pkg::S_OUT: begin
                if (load_out) begin
                    n_state = rcwm_pkg::S_IDLE;
                end
            end
            default: n_state = rcwm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        pix_we        = 1'b0;
        wgt_we        = 1'b0;
        wgt_raddr     = WAW'(int'(r_k) * MAX_KERNEL + int'(r_q));
        load_out      = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.vld   = r_s1_vld;
        case (r_state)
            rcwm_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                wgt_raddr     = WAW'(int'(in_row) * MAX_KERNEL + int'(in_col));
                pix_we        = in_xfer && (in_op == rcwm_pkg::OP_PIXEL) && pix_ok;
                mac_ctl.clear = in_xfer && (in_op == rcwm_pkg::OP_COMPUTE);
            end
            rcwm_pkg::S_WMERGE: wgt_we = 1'b1;
            rcwm_pkg::S_OUT:    load_out = !r_out_vld || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rcwm_pkg::S_IDLE;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_img_w   <= POS_W'(256);
            r_img_h   <= POS_W'(256);
            r_ksize   <= KS_W'(3);
            r_bias    <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == rcwm_pkg::S_RUN) && win_in;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rcwm_pkg::CFG_IMG_W: r_img_w <= i_cfg_data[POS_W-1:0];
                    rcwm_pkg::CFG_IMG_H: r_img_h <= i_cfg_data[POS_W-1:0];
                    rcwm_pkg::CFG_KSIZE: r_ksize <= i_cfg_data[KS_W-1:0];
                    rcwm_pkg::CFG_BIAS:  r_bias  <= $signed(i_cfg_data[rcwm_pkg::BIAS_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // payload and window counters
    always_ff @(posedge i_clk) begin
        if (r_state == rcwm_pkg::S_IDLE && in_xfer) begin
            r_row   <= in_row;
            r_col   <= in_col;
            r_filt  <= in_filt;
            r_k     <= '0;
            r_q     <= '0;
            r_drain <= 1'b0;
            r_wsel  <= in_chan;
            r_waddr <= wgt_raddr;
            r_wval  <= in_wgt;
        end else if (r_state == rcwm_pkg::S_RUN) begin
            if (last_q) begin
                r_q <= '0;
                r_k <= r_k + KS_W'(1);
            end else begin
                r_q <= r_q + KS_W'(1);
            end
        end else if (r_state == rcwm_pkg::S_DRAIN) begin
            r_drain <= 1'b1;
        end
        if (load_out) begin
            r_out_sum  <= mac_sum;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_filt <= r_filt;
        end
    end

    rcwm_ram #(
        .WIDTH (rcwm_pkg::PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (in_pix),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    rcwm_ram #(
        .WIDTH (WWORD_W),
        .DEPTH (WGT_DEPTH)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (r_waddr),
        .i_wdata (wgt_wdata),
        .i_raddr (wgt_raddr),
        .o_rdata (wgt_rdata)
    );

    rcwm_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_pix   (pix_rdata),
        .i_wgt   (wgt_rdata),
        .i_bias  (r_bias),
        .o_sum   (mac_sum)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out_filt, r_out_col, r_out_row, r_out_sum};

endmodule

// File: tb/rgb_conv_window_mac_test.sv
module rgb_conv_window_mac_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W       = rcwm_pkg::OP_W;
    localparam int POS_W      = rcwm_pkg::POS_W;
    localparam int CHAN_W     = rcwm_pkg::CHAN_W;
    localparam int WGT_W      = rcwm_pkg::WGT_W;
    localparam int COMP_W     = rcwm_pkg::COMP_W;
    localparam int FILT_W     = rcwm_pkg::FILT_W;
    localparam int SUM_W      = rcwm_pkg::SUM_W;
    localparam int PIX_W      = rcwm_pkg::PIX_W;
    localparam int BIAS_W     = rcwm_pkg::BIAS_W;
    localparam int KS_W       = rcwm_pkg::KS_W;
    localparam int NCH        = rcwm_pkg::NCH;
    localparam int S_DATA_W   = rcwm_pkg::S_DATA_W;
    localparam int M_DATA_W   = rcwm_pkg::M_DATA_W;
    localparam int CFG_IDX_W  = rcwm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rcwm_pkg::CFG_DATA_W;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int KMAX = rcwm_pkg::DEF_MAX_KERNEL;
    localparam int HMAX = rcwm_pkg::DEF_MAX_HEIGHT;
    localparam int WMAX = rcwm_pkg::DEF_MAX_WIDTH;
    localparam int POS_TOP = 262;
    // longest compute is a full 7x7 window plus drain and output
    localparam int DRAIN_CYCLES = KMAX * KMAX + 16;
    localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [CHAN_W-1:0] chan;
        logic [WGT_W-1:0]  wgt;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [FILT_W-1:0] filt;
    } t_conv_req;

    typedef struct {
        logic [SUM_W-1:0]  sum;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [FILT_W-1:0] filt;
    } t_conv_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the engine: registers and both stores
    int                      img_w = 256;
    int                      img_h = 256;
    int                      ksize = 3;
    logic signed [BIAS_W-1:0] bias = '0;
    logic signed [WGT_W-1:0] wgt_mem [NCH][KMAX][KMAX];
    bit                      wgt_set [NCH][KMAX][KMAX];
    logic [PIX_W-1:0]        pix_mem [HMAX][WMAX];
    bit                      pix_set [HMAX][WMAX];

    t_conv_result pending_sums [$];
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           last_effective;

    rgb_conv_window_mac dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // returns 0 if the window touches a store entry never written
    function automatic bit window_acc(int r, int c, output longint acc);
        int ks, h, hgt, wid, pr, pc;
        bit ok;
        ks  = (ksize > KMAX) ? KMAX : ksize;
        h   = ks / 2;
        hgt = (img_h > HMAX) ? HMAX : img_h;
        wid = (img_w > WMAX) ? WMAX : img_w;
        acc = bias;
        ok  = 1'b1;
        for (int k = 0; k < ks; k++) begin
            pr = r - h + k;
            if (pr < 0 || pr >= hgt) continue;
            for (int q = 0; q < ks; q++) begin
                pc = c - h + q;
                if (pc < 0 || pc >= wid) continue;
                ok &= pix_set[pr][pc];
                for (int ch = 0; ch < NCH; ch++) begin
                    ok &= wgt_set[ch][k][q];
                    acc += longint'(pix_mem[pr][pc][PIX_W-1-COMP_W*ch -: COMP_W])
                         * longint'(wgt_mem[ch][k][q]);
                end
            end
        end
        return ok;
    endfunction

    // updates the shadow state; returns 0 when the engine ignores the item
    function automatic bit conv_apply(t_conv_req it);
        longint       acc;
        t_conv_result res;
        case (it.op)
            rcwm_pkg::OP_WEIGHT: begin
                if (it.chan >= NCH || it.row >= KMAX || it.col >= KMAX) return 1'b0;
                wgt_mem[it.chan][it.row][it.col] = it.wgt;
                wgt_set[it.chan][it.row][it.col] = 1'b1;
            end
            rcwm_pkg::OP_PIXEL: begin
                if (it.row >= HMAX || it.col >= WMAX) return 1'b0;
                pix_mem[it.row][it.col] = {it.red, it.green, it.blue};
                pix_set[it.row][it.col] = 1'b1;
            end
            rcwm_pkg::OP_COMPUTE: begin
                void'(window_acc(int'(it.row), int'(it.col), acc));
                if (acc > SUM_HI) acc = SUM_HI;
                if (acc < SUM_LO) acc = SUM_LO;
                res.sum  = acc[SUM_W-1:0];
                res.row  = it.row;
                res.col  = it.col;
                res.filt = it.filt;
                pending_sums.push_back(res);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_conv_result got;
        t_conv_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sum  = m_axis_tdata[31:0];
            got.row  = m_axis_tdata[40:32];
            got.col  = m_axis_tdata[49:41];
            got.filt = m_axis_tdata[57:50];
            if (pending_sums.size() == 0) begin
                $error("result transfer with no compute pending: sum_out %0d row %0d col %0d",
                       $signed(got.sum), got.row, got.col);
                err_count++;
            end else begin
                want = pending_sums.pop_front();
                check_field("sum_out", 64'($signed(want.sum)), 64'($signed(got.sum)));
                check_field("out_row", 64'(want.row), 64'(got.row));
                check_field("out_col", 64'(want.col), 64'(got.col));
                check_field("out_filter", 64'(want.filt), 64'(got.filt));
            end
        end
    end

    function automatic t_conv_req req_of(logic [OP_W-1:0] op, int row, int col);
        t_conv_req it;
        it.op    = op;
        it.row   = POS_W'(row);
        it.col   = POS_W'(col);
        it.chan  = CHAN_W'($urandom);
        it.wgt   = WGT_W'($urandom);
        it.red   = COMP_W'($urandom);
        it.green = COMP_W'($urandom);
        it.blue  = COMP_W'($urandom);
        it.filt  = FILT_W'($urandom);
        return it;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(t_conv_req it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {4'd0, it.filt, it.blue, it.green, it.red, it.wgt, it.chan,
                          it.col, it.row};
        s_axis_tuser  <= it.op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_effective = conv_apply(it);
        @(negedge i_clk);
    endtask

    task automatic put_pixel(int row, int col, logic [PIX_W-1:0] rgb);
        t_conv_req it;
        it = req_of(rcwm_pkg::OP_PIXEL, row, col);
        {it.red, it.green, it.blue} = rgb;
        send_item(it);
    endtask

    task automatic put_weight(int ch, int row, int col, logic [WGT_W-1:0] w);
        t_conv_req it;
        it = req_of(rcwm_pkg::OP_WEIGHT, row, col);
        it.chan = CHAN_W'(ch);
        it.wgt  = w;
        send_item(it);
    endtask

    task automatic ask_sum(int row, int col, logic [FILT_W-1:0] filt);
        t_conv_req it;
        it = req_of(rcwm_pkg::OP_COMPUTE, row, col);
        it.filt = filt;
        send_item(it);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        // writes give no result, so the engine may still be busy with one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        settle();
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rcwm_pkg::CFG_IMG_W: img_w = int'(val[POS_W-1:0]);
            rcwm_pkg::CFG_IMG_H: img_h = int'(val[POS_W-1:0]);
            rcwm_pkg::CFG_KSIZE: ksize = int'(val[KS_W-1:0]);
            rcwm_pkg::CFG_BIAS:  bias  = val[BIAS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_pixels(int nr, int nc);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (!pix_set[r][c]) put_pixel(r, c, PIX_W'($urandom));
    endtask

    task automatic test_weight_load();
        logic [WGT_W-1:0] w;
        for (int ch = 0; ch < NCH; ch++)
            for (int k = 0; k < KMAX; k++)
                for (int q = 0; q < KMAX; q++) begin
                    w = WGT_W'($urandom);
                    if (k == q) w = (ch == 1) ? 16'h7fff : 16'h8000;
                    put_weight(ch, k, q, w);
                end
    endtask

    task automatic test_directed();
        t_conv_req it;
        put_pixel(0, 0, 24'hffffff);
        put_pixel(0, 1, 24'h000000);
        put_pixel(1, 0, PIX_W'($urandom));
        put_pixel(1, 1, PIX_W'($urandom));
        put_pixel(HMAX - 1, WMAX - 1, 24'hffffff);
        // writes outside the stores must leave them alone
        put_pixel(HMAX, 0, 24'h123456);
        put_pixel(0, POS_TOP, 24'h654321);
        put_pixel(POS_TOP, POS_TOP, 24'hffffff);
        put_weight(3, 0, 0, 16'h7fff);
        put_weight(0, KMAX, 0, 16'h7fff);
        put_weight(1, 0, KMAX, 16'h8000);
        it = req_of(OP_UNUSED, 0, 0);
        it.row = '1;
        it.col = '1;
        send_item(it);
        ask_sum(0, 0, 8'h00);
        ask_sum(256, 256, 8'hff);
        ask_sum(257, 257, 8'haa);
        ask_sum(POS_TOP, POS_TOP, 8'h55);
        ask_sum(0, POS_TOP, 8'h0f);
        ask_sum(POS_TOP, 0, 8'hf0);
        // most negative and most positive weights under a full-scale pixel
        put_weight(0, 1, 1, 16'h8000);
        put_weight(2, 1, 1, 16'h7fff);
        ask_sum(0, 0, 8'h81);
    endtask

    task automatic test_register_extremes();
        fill_pixels(8, 8);
        write_reg(rcwm_pkg::CFG_BIAS, 24'h7fffff);
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(3, 3, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_BIAS, 24'h800000);
        ask_sum(0, 0, FILT_W'($urandom));
        // empty window gives the bias alone
        write_reg(rcwm_pkg::CFG_KSIZE, 0);
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(POS_TOP, POS_TOP, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_KSIZE, 1);
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(7, 7, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_KSIZE, 7);
        ask_sum(3, 3, FILT_W'($urandom));
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(4, 4, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_IMG_W, 0);
        ask_sum(3, 3, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_IMG_W, 8);
        write_reg(rcwm_pkg::CFG_IMG_H, 0);
        ask_sum(3, 3, FILT_W'($urandom));
        write_reg(rcwm_pkg::CFG_IMG_W, 1);
        write_reg(rcwm_pkg::CFG_IMG_H, 1);
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(3, 3, FILT_W'($urandom));
        // oversized dimensions clamp to the store size
        write_reg(rcwm_pkg::CFG_KSIZE, 3);
        write_reg(rcwm_pkg::CFG_IMG_W, 511);
        write_reg(rcwm_pkg::CFG_IMG_H, 511);
        ask_sum(256, 256, FILT_W'($urandom));
        ask_sum(0, 0, FILT_W'($urandom));
        ask_sum(4, 4, FILT_W'($urandom));
    endtask

    task automatic run_phase(int w, int hh, int ks, int idle_pct, int stall_pct, int n_items);
        int        eff_w, eff_h, half, reg_r, reg_c, done, r, c, tries, pick;
        t_conv_req it;
        longint    acc;
        write_reg(rcwm_pkg::CFG_IMG_W, w);
        write_reg(rcwm_pkg::CFG_IMG_H, hh);
        write_reg(rcwm_pkg::CFG_KSIZE, ks);
        write_reg(rcwm_pkg::CFG_BIAS, int'($urandom));
        eff_w = (w > WMAX) ? WMAX : w;
        eff_h = (hh > HMAX) ? HMAX : hh;
        reg_r = (eff_h < 16) ? eff_h : 16;
        reg_c = (eff_w < 16) ? eff_w : 16;
        half  = ks / 2;
        fill_pixels(reg_r, reg_c);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                it = req_of(OP_UNUSED, $urandom_range(POS_TOP), $urandom_range(POS_TOP));
            end else if (pick < 23) begin
                it = req_of(rcwm_pkg::OP_WEIGHT, $urandom_range(KMAX), $urandom_range(KMAX));
                if ($urandom_range(9) == 0) it.wgt = $urandom_range(1) ? 16'h7fff : 16'h8000;
            end else if (pick < 53) begin
                if (reg_r > 0 && reg_c > 0 && $urandom_range(4) != 0)
                    it = req_of(rcwm_pkg::OP_PIXEL, $urandom_range(reg_r - 1),
                                $urandom_range(reg_c - 1));
                else
                    it = req_of(rcwm_pkg::OP_PIXEL, $urandom_range(POS_TOP),
                                $urandom_range(POS_TOP));
            end else begin
                // only windows over written entries; far corner is padding only
                tries = 0;
                do begin
                    if ($urandom_range(6) == 0) begin
                        r = $urandom_range(POS_TOP);
                        c = $urandom_range(POS_TOP);
                    end else begin
                        r = $urandom_range(reg_r + 2 * half);
                        c = $urandom_range(reg_c + 2 * half);
                    end
                    tries++;
                end while (!window_acc(r, c, acc) && tries < 16);
                if (!window_acc(r, c, acc)) begin
                    r = POS_TOP;
                    c = POS_TOP;
                end
                it = req_of(rcwm_pkg::OP_COMPUTE, r, c);
            end
            send_item(it);
            if (last_effective) done++;
        end
    endtask

    task automatic test_random_phases();
        run_phase(8, 6, 3, 0, 0, 90);
        run_phase(12, 12, 5, 71, 0, 90);
        run_phase(1, 1, 7, 0, 71, 90);
        run_phase(511, 511, 3, 36, 36, 90);
        run_phase(5, 9, 1, 0, 0, 90);
        run_phase(7, 7, 2, 71, 0, 90);
        run_phase(16, 10, 7, 0, 71, 90);
        run_phase(300, 256, 4, 36, 36, 90);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_weight_load();
        test_directed();
        test_register_extremes();
        test_random_phases();
        settle();
        if (err_count == 0 && pending_sums.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
